// ----- rtl/nd_transpose_index_generator_macros.svh -----
// Assertion helpers shared by the RTL; clock and reset are the house names.
`ifndef ND_TRANSPOSE_INDEX_GENERATOR_MACROS_SVH
`define ND_TRANSPOSE_INDEX_GENERATOR_MACROS_SVH

// Property checked on every edge outside reset.
`define NDTIG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define NDTIG_ASSERT_NXT(lbl, ante, cons, msg) \
  `NDTIG_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- rtl/ndtig_pkg.sv -----
package ndtig_pkg;

  localparam int MAX_DIMS_DEF   = 6;
  localparam int INDEX_BITS_DEF = 32;

  localparam int VALUE_W     = 64;
  localparam int FIELD_IDX_W = 32;
  localparam int DIGIT_W     = 12;
  localparam int BOUND_W     = 13;
  localparam int DIMS_W      = 3;

  localparam int NUM_BOUND_REGS = 6;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 13;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST       = 3'd6;

  localparam logic [DIMS_W-1:0]  NUM_DIMS_RESET = 3'd2;
  localparam logic [BOUND_W-1:0] BOUND_RESET    = 13'd1;
  localparam logic [BOUND_W-1:0] BOUND_MAX      = 13'd4096;

  // Control handed from the top level to every cell.
  typedef struct packed {
    logic restart;
    logic advance;
    logic last;
  } cell_ctrl_t;

  // Status a cell reports back.
  typedef struct packed {
    logic carry;
    logic at_max;
    logic is_k;
  } cell_stat_t;

  // Zero reads as one, anything above the maximum as the maximum.
  function automatic logic [BOUND_W-1:0] clamp_bound(input logic [BOUND_W-1:0] b);
    logic [BOUND_W-1:0] r;
    r = b;
    if (b == '0) begin
      r = BOUND_W'(1);
    end else if (b > BOUND_MAX) begin
      r = BOUND_MAX;
    end
    return r;
  endfunction

endpackage

// ----- rtl/ndtig_cell.sv -----
module ndtig_cell
  import ndtig_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic                  active_i,
  input  logic [BOUND_W-1:0]    bound_i,
  input  logic [INDEX_BITS-1:0] stride_i,
  input  logic [INDEX_BITS-1:0] top_span_i,
  input  logic                  carry_i,
  output logic [INDEX_BITS-1:0] span_o,
  output logic [INDEX_BITS-1:0] delta_o,
  output cell_stat_t            stat_o
);

  localparam int PW = INDEX_BITS + BOUND_W;

  logic [DIGIT_W-1:0]    digit_q;
  logic [BOUND_W-1:0]    digit_inc;
  logic                  at_top;
  logic                  inc;
  logic [PW-1:0]         prod;
  logic [INDEX_BITS-1:0] span_q;
  logic [INDEX_BITS-1:0] delta_q;

  assign digit_inc = BOUND_W'(digit_q) + BOUND_W'(1);
  assign at_top    = (digit_inc == bound_i);
  assign inc       = carry_i & active_i;

  assign stat_o.carry  = inc & at_top;
  assign stat_o.is_k   = inc & ~at_top;
  assign stat_o.at_max = at_top | ~active_i;

  // Span of this digit is the stride of the next one up.
  assign prod   = PW'(stride_i) * PW'(bound_i);
  assign span_o = span_q;

  // Net index step when this digit is the one that takes the increment.
  assign delta_o = stat_o.is_k ? delta_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else if (ctrl_i.restart || (ctrl_i.advance && ctrl_i.last)) begin
      digit_q <= '0;
    end else if (ctrl_i.advance && inc) begin
      digit_q <= at_top ? '0 : digit_inc[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    span_q  <= prod[INDEX_BITS-1:0];
    delta_q <= stride_i + span_q - top_span_i;
  end

endmodule

// ----- rtl/nd_transpose_index_generator.sv -----
// A result appears in the output register in the cycle after its transaction.
// Throughput: one element per cycle while the output side keeps up.
// Strides travel down the cell chain one multiplier per cell, so after reset and after
// every write to a known register the input stalls until the settle counter reaches SETTLE.
// Reset: async active low; num_dims = 2, every bound = 1, walk at the origin.
`include "nd_transpose_index_generator_macros.svh"

module nd_transpose_index_generator
  import ndtig_pkg::*;
#(
  parameter int MAX_DIMS   = MAX_DIMS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // elem_value[63:0]
  input  logic [VALUE_W-1:0]     s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_value[63:0], src_index[95:64], dst_index[127:96]
  output logic [VALUE_W+2*FIELD_IDX_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  localparam int DW     = $clog2(MAX_DIMS + 1);
  localparam int SETTLE = MAX_DIMS + 2;
  localparam int CW     = $clog2(SETTLE + 1);

  logic [DIMS_W-1:0]     num_dims_q;
  logic [BOUND_W-1:0]    bound_q [NUM_BOUND_REGS];
  logic [CW-1:0]         cnt_q;
  logic [INDEX_BITS-1:0] src_q;
  logic [INDEX_BITS-1:0] dst_q;
  logic [INDEX_BITS-1:0] top_span_q;
  logic                  m_valid_q;
  logic [VALUE_W-1:0]    out_value_q;
  logic [FIELD_IDX_W-1:0] out_src_q;
  logic [FIELD_IDX_W-1:0] out_dst_q;
  logic                  out_last_q;

  logic                  settled;
  logic                  cfg_hit;
  logic                  in_acc;
  logic                  last_w;
  logic [DIMS_W-1:0]     nd_clamp;
  logic [DW-1:0]         eff_dims;
  logic [DW-1:0]         top_w;
  logic [INDEX_BITS-1:0] top_span_d;
  logic [INDEX_BITS-1:0] delta_sum;
  logic [MAX_DIMS-1:0]   at_max_vec;
  logic [MAX_DIMS-1:0]   is_k_vec;
  cell_ctrl_t            ctrl;

  logic [INDEX_BITS-1:0] span_w  [MAX_DIMS];
  logic [INDEX_BITS-1:0] delta_w [MAX_DIMS];
  cell_stat_t            stat_w  [MAX_DIMS];

  always_comb begin
    nd_clamp = num_dims_q;
    if (num_dims_q == '0) begin
      nd_clamp = DIMS_W'(1);
    end else if (num_dims_q > MAX_DIMS) begin
      nd_clamp = DIMS_W'(MAX_DIMS);
    end
  end

  assign eff_dims = DW'(nd_clamp);
  assign top_w    = eff_dims - DW'(1);

  assign settled       = (cnt_q == CW'(SETTLE));
  assign cfg_hit       = cfg_we_i && (cfg_idx_i <= REG_LAST);
  assign s_axis_tready = settled && (!m_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign last_w        = &at_max_vec;

  assign ctrl.restart = cfg_hit;
  assign ctrl.advance = in_acc && !cfg_hit;
  assign ctrl.last    = last_w;

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cell
    logic [BOUND_W-1:0]    bound_eff;
    logic [INDEX_BITS-1:0] stride_in;
    logic                  carry_in;

    if (d < NUM_BOUND_REGS) begin : g_reg
      assign bound_eff = clamp_bound(bound_q[d]);
    end else begin : g_one
      assign bound_eff = BOUND_W'(1);
    end

    if (d == 0) begin : g_origin
      assign stride_in = INDEX_BITS'(1);
    end else begin : g_link
      assign stride_in = span_w[d-1];
    end

    // The top digit takes the increment; lower digits see the carry from above.
    if (d == MAX_DIMS - 1) begin : g_head
      assign carry_in = (top_w == DW'(d));
    end else begin : g_body
      assign carry_in = (top_w == DW'(d)) | stat_w[d+1].carry;
    end

    ndtig_cell #(
      .INDEX_BITS (INDEX_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .active_i   (DW'(d) < eff_dims),
      .bound_i    (bound_eff),
      .stride_i   (stride_in),
      .top_span_i (top_span_q),
      .carry_i    (carry_in),
      .span_o     (span_w[d]),
      .delta_o    (delta_w[d]),
      .stat_o     (stat_w[d])
    );

    assign at_max_vec[d] = stat_w[d].at_max;
    assign is_k_vec[d]   = stat_w[d].is_k;
  end

  always_comb begin
    top_span_d = '0;
    delta_sum  = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (top_w == DW'(d)) begin
        top_span_d = top_span_d | span_w[d];
      end
      delta_sum = delta_sum | delta_w[d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= NUM_DIMS_RESET;
      for (int i = 0; i < NUM_BOUND_REGS; i++) begin
        bound_q[i] <= BOUND_RESET;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_NUM_DIMS) begin
        num_dims_q <= cfg_data_i[DIMS_W-1:0];
      end
      for (int i = 0; i < NUM_BOUND_REGS; i++) begin
        if (cfg_idx_i == REG_BOUND_BASE + CFG_IDX_W'(i)) begin
          bound_q[i] <= cfg_data_i[BOUND_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      src_q     <= '0;
      dst_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_hit) begin
        // rewind the walk and let the strides settle again
        cnt_q <= '0;
        src_q <= '0;
        dst_q <= '0;
      end else begin
        if (!settled) begin
          cnt_q <= cnt_q + CW'(1);
        end
        if (in_acc) begin
          if (last_w) begin
            src_q <= '0;
            dst_q <= '0;
          end else begin
            src_q <= src_q + INDEX_BITS'(1);
            dst_q <= dst_q + delta_sum;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_span_q <= top_span_d;
    if (in_acc) begin
      out_value_q <= s_axis_tdata;
      out_src_q   <= FIELD_IDX_W'(src_q);
      out_dst_q   <= FIELD_IDX_W'(dst_q);
      out_last_q  <= last_w;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_dst_q, out_src_q, out_value_q};
  assign m_axis_tlast  = out_last_q;

  `NDTIG_ASSERT_NXT(a_last_rewinds,
    in_acc && last_w, src_q == '0 && dst_q == '0, "walk not rewound after last element")
  `NDTIG_ASSERT(a_one_digit_bumps,
    (in_acc && !last_w) |-> $onehot(is_k_vec), "increment must land on exactly one digit")
  `NDTIG_ASSERT_NXT(a_src_steps, in_acc && !last_w && !cfg_hit,
    src_q == $past(src_q) + 1'b1, "source index did not advance by one")
  `NDTIG_ASSERT_NXT(a_cfg_resettles, cfg_hit,
    !settled && src_q == '0 && dst_q == '0, "configuration write must restart the walk")

endmodule
